// ===== rtl/sqd_pkg.sv =====
// ----------------------------------------------------------------------------
// sqd_pkg
// shared types and constants of the squared l2 distance block
// ----------------------------------------------------------------------------
package sqd_pkg;

   localparam int ELEM_W  = 8;
   localparam int LEN_W   = 11;
   localparam int DIST_W  = 26;
   localparam int INDEX_W = 16;
   localparam int ADDR_W  = 16;
   localparam int SQ_W    = 17;

   localparam logic [LEN_W-1:0]  LEN_RESET = 11'd128;
   localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_CAND = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic                      is_cand;
      logic                      first;
      logic                      last;
      logic [ADDR_W-1:0]         addr;
      logic signed [ELEM_W-1:0]  value;
      logic [INDEX_W-1:0]        index;
   } op_type;

endpackage

// ===== rtl/sqd_req_if.sv =====
// ----------------------------------------------------------------------------
// sqd_req_if
// request channel: action and element value with valid/ready
// ----------------------------------------------------------------------------
interface sqd_req_if;
   logic                             valid;
   logic                             ready;
   logic                             action;
   logic signed [sqd_pkg::ELEM_W-1:0] element_value;

   modport source (output valid, action, element_value, input ready);
   modport sink   (input valid, action, element_value, output ready);
endinterface

// ===== rtl/sqd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sqd_rsp_if
// result channel: distance and candidate index with valid/ready
// ----------------------------------------------------------------------------
interface sqd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sqd_pkg::DIST_W-1:0]    distance;
   logic [sqd_pkg::INDEX_W-1:0]   candidate_index;

   modport source (output valid, distance, candidate_index, input ready);
   modport sink   (input valid, distance, candidate_index, output ready);
endinterface

// ===== rtl/sqd_front.sv =====
// ----------------------------------------------------------------------------
// sqd_front
// accepts requests, tracks positions and candidate count, issues operations
// ----------------------------------------------------------------------------
module sqd_front #(
   parameter int MAX_LEN = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [sqd_pkg::LEN_W-1:0]       csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic signed [sqd_pkg::ELEM_W-1:0] req_element_value,
   input  logic                            q_full,
   output logic                            q_push,
   output sqd_pkg::op_type                 q_op
);

   localparam int PW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LW0 = $clog2(MAX_LEN + 1);
   localparam int LW  = (LW0 > sqd_pkg::LEN_W) ? LW0 : sqd_pkg::LEN_W;

   logic [sqd_pkg::LEN_W-1:0]   len_ff;
   logic [PW-1:0]               load_pos_ff, load_pos_in;
   logic [PW-1:0]               elem_pos_ff, elem_pos_in;
   logic [sqd_pkg::INDEX_W-1:0] vcount_ff, vcount_in;
   logic                        sum_clr_ff, sum_clr_in;

   logic [LW-1:0] len_raw, len, lp, lp_next, ep, ep_next;
   logic          accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;
   assign len_raw   = LW'(len_ff);

   always_comb begin
      if (len_ff == '0) begin
         len = LW'(1);
      end else if (len_raw > LW'(MAX_LEN)) begin
         len = LW'(MAX_LEN);
      end else begin
         len = len_raw;
      end

      lp      = (LW'(load_pos_ff) >= len) ? '0 : LW'(load_pos_ff);
      ep      = (LW'(elem_pos_ff) >= len) ? '0 : LW'(elem_pos_ff);
      lp_next = lp + LW'(1);
      ep_next = ep + LW'(1);

      load_pos_in = load_pos_ff;
      elem_pos_in = elem_pos_ff;
      vcount_in   = vcount_ff;
      sum_clr_in  = sum_clr_ff;

      // running sum restarts only after reset, a load or a finished candidate
      q_op.is_cand = (req_action == sqd_pkg::ACT_CAND);
      q_op.value   = req_element_value;
      q_op.index   = vcount_ff;
      q_op.first   = sum_clr_ff;
      q_op.last    = (ep_next >= len);

      if (req_action == sqd_pkg::ACT_CAND) begin
         q_op.addr = sqd_pkg::ADDR_W'(ep);
         if (ep_next >= len) begin
            elem_pos_in = '0;
            vcount_in   = vcount_ff + sqd_pkg::INDEX_W'(1);
            sum_clr_in  = 1'b1;
         end else begin
            elem_pos_in = PW'(ep_next);
            sum_clr_in  = 1'b0;
         end
      end else begin
         q_op.addr   = sqd_pkg::ADDR_W'(lp);
         elem_pos_in = '0;
         sum_clr_in  = 1'b1;
         if (lp == '0) begin
            vcount_in = '0;
         end
         load_pos_in = (lp_next >= len) ? '0 : PW'(lp_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= sqd_pkg::LEN_RESET;
         load_pos_ff <= '0;
         elem_pos_ff <= '0;
         vcount_ff   <= '0;
         sum_clr_ff  <= 1'b1;
      end else begin
         if (csr_we) begin
            len_ff <= csr_wdata;
         end
         if (accept) begin
            load_pos_ff <= load_pos_in;
            elem_pos_ff <= elem_pos_in;
            vcount_ff   <= vcount_in;
            sum_clr_ff  <= sum_clr_in;
         end
      end
   end

endmodule

// ===== rtl/sqd_queue.sv =====
// ----------------------------------------------------------------------------
// sqd_queue
// short operation queue between front and back
// ----------------------------------------------------------------------------
module sqd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  sqd_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output logic            empty,
   output sqd_pkg::op_type head_op
);

   sqd_pkg::op_type                entry_ff [sqd_pkg::QUEUE_DEPTH];
   logic [sqd_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [sqd_pkg::QPTR_W:0]       count_ff;
   logic                           do_push, do_pop;

   assign full    = (count_ff == (sqd_pkg::QPTR_W+1)'(sqd_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_op = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + sqd_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + sqd_pkg::QPTR_W'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (sqd_pkg::QPTR_W+1)'(1);
            2'b01:   count_ff <= count_ff - (sqd_pkg::QPTR_W+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/sqd_back.sv =====
// ----------------------------------------------------------------------------
// sqd_back
// query memory, difference, square, accumulate and result register
// ----------------------------------------------------------------------------
module sqd_back #(
   parameter int MAX_LEN = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  sqd_pkg::op_type                q_head,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sqd_pkg::DIST_W-1:0]     rsp_distance,
   output logic [sqd_pkg::INDEX_W-1:0]    rsp_candidate_index
);

   localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic signed [sqd_pkg::ELEM_W-1:0] mem [MAX_LEN];

   logic                              advance;
   logic                              take;

   // stage 1: query read
   logic                              s1_valid_ff;
   logic                              s1_first_ff, s1_last_ff;
   logic [sqd_pkg::INDEX_W-1:0]       s1_index_ff;
   logic signed [sqd_pkg::ELEM_W-1:0] s1_x_ff, s1_q_ff;

   // stage 2: square
   logic                              s2_valid_ff;
   logic                              s2_first_ff, s2_last_ff;
   logic [sqd_pkg::INDEX_W-1:0]       s2_index_ff;
   logic [sqd_pkg::SQ_W-1:0]          sq_ff;

   // stage 3: accumulate and result, running sum saturates
   logic [sqd_pkg::DIST_W-1:0]        acc_ff, acc_in, acc_base;
   logic [sqd_pkg::DIST_W:0]          acc_sum;
   logic                              rsp_valid_ff;
   logic [sqd_pkg::DIST_W-1:0]        dist_ff;
   logic [sqd_pkg::INDEX_W-1:0]       index_ff;

   logic signed [sqd_pkg::ELEM_W:0]   diff;
   logic signed [2*sqd_pkg::ELEM_W+1:0] prod;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign take    = advance && !q_empty;
   assign q_pop   = take;

   assign diff = {s1_q_ff[sqd_pkg::ELEM_W-1], s1_q_ff} - {s1_x_ff[sqd_pkg::ELEM_W-1], s1_x_ff};
   assign prod = diff * diff;

   always_comb begin
      acc_base = s2_first_ff ? '0 : acc_ff;
      acc_sum  = {1'b0, acc_base} + (sqd_pkg::DIST_W+1)'(sq_ff);
      if (acc_sum > {1'b0, sqd_pkg::DIST_MAX}) begin
         acc_in = sqd_pkg::DIST_MAX;
      end else begin
         acc_in = acc_sum[sqd_pkg::DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         if (q_head.is_cand) begin
            s1_q_ff <= mem[q_head.addr[PW-1:0]];
         end else begin
            mem[q_head.addr[PW-1:0]] <= q_head.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_first_ff <= q_head.first;
         s1_last_ff  <= q_head.last;
         s1_index_ff <= q_head.index;
         s1_x_ff     <= q_head.value;
         s2_first_ff <= s1_first_ff;
         s2_last_ff  <= s1_last_ff;
         s2_index_ff <= s1_index_ff;
         sq_ff       <= sqd_pkg::SQ_W'(prod);
         if (s2_valid_ff) begin
            acc_ff <= acc_in;
         end
         if (s2_valid_ff && s2_last_ff) begin
            dist_ff  <= acc_in;
            index_ff <= s2_index_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= take && q_head.is_cand;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff && s2_last_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_distance        = dist_ff;
   assign rsp_candidate_index = index_ff;

endmodule

// ===== rtl/batch_squared_l2_distance.sv =====
// ----------------------------------------------------------------------------
// batch_squared_l2_distance
// squared euclidean distance of a stream of candidates against one query
// ----------------------------------------------------------------------------
// One request is taken per clock cycle, loads and candidate elements alike,
// as long as the four-entry operation queue has room. Each candidate element
// makes one read of the single-port query memory, then a square and an
// accumulate stage, which registers the result of a candidate after its
// last element. The result waits in an output register; while
// it is not taken the pipeline holds, the queue fills and then the request
// side stalls. A partial sum survives a length change that restarts the
// element position, and the sum saturates at the largest 26-bit distance.
// The query memory has no reset; candidates must not read query elements
// that were never loaded.
module batch_squared_l2_distance #(
   parameter int MAX_LEN = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   sqd_req_if.sink                   req_chan,
   sqd_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [sqd_pkg::LEN_W-1:0] csr_wdata
);

   logic            q_push, q_full, q_pop, q_empty;
   sqd_pkg::op_type push_op, head_op;

   sqd_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_action        (req_chan.action),
      .req_element_value (req_chan.element_value),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_op              (push_op)
   );

   sqd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (push_op),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .head_op (head_op)
   );

   sqd_back #(.MAX_LEN(MAX_LEN)) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_head              (head_op),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_distance        (rsp_chan.distance),
      .rsp_candidate_index (rsp_chan.candidate_index)
   );

endmodule

// ===== rtl/sqd_checker.sv =====
// ----------------------------------------------------------------------------
// sqd_checker
// port-level checks on the squared l2 distance block
// ----------------------------------------------------------------------------
module sqd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_action,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sqd_pkg::DIST_W-1:0]    rsp_distance,
   input logic [sqd_pkg::INDEX_W-1:0]   rsp_candidate_index
);

   // candidate elements taken minus results delivered
   logic [31:0] pend_ff;
   logic        cand_acc, rsp_acc;

   assign cand_acc = req_valid && req_ready && (req_action == sqd_pkg::ACT_CAND);
   assign rsp_acc  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         case ({cand_acc, rsp_acc})
            2'b10:   pend_ff <= pend_ff + 32'd1;
            2'b01:   pend_ff <= pend_ff - 32'd1;
            default: pend_ff <= pend_ff;
         endcase
      end
   end

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_distance) && $stable(rsp_candidate_index))
      else $error("result changed while stalled");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_invented : assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> pend_ff != 32'd0)
      else $error("result without a candidate element");

endmodule

bind batch_squared_l2_distance sqd_checker u_sqd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .req_action          (req_chan.action),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_distance        (rsp_chan.distance),
   .rsp_candidate_index (rsp_chan.candidate_index)
);
